// File: hdl/dsc_pkg.sv
package dsc_pkg;

    localparam int unsigned BUFFER_DEPTH_DEFAULT = 512;

    localparam int unsigned OP_W          = 3;
    localparam int unsigned SAMPLE_W      = 32;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned QUALITY_W     = 8;
    localparam int unsigned READ_INDEX_W  = 9;
    localparam int unsigned COUNT_W       = 10;
    localparam int unsigned DECIM_W       = 8;

    localparam int unsigned IN_TDATA_W    = 88;
    localparam int unsigned OUT_TDATA_W   = 48;

    localparam int unsigned CFG_INDEX_W   = 1;
    localparam int unsigned CFG_DATA_W    = 32;

    localparam logic [TIME_W-1:0]  TIMEOUT_RESET    = 32'd10000;
    localparam logic [DECIM_W-1:0] DECIMATION_RESET = 8'd5;
    localparam logic [QUALITY_W-1:0] QUALITY_GOOD   = 8'd1;

    typedef enum logic [OP_W-1:0] {
        OP_FEED    = 3'd0,
        OP_REQUEST = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_ACQUIRE = 3'd3,
        OP_RELEASE = 3'd4,
        OP_READ    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_NONE      = 2'd0,
        ST_STARTED   = 2'd1,
        ST_BUSY      = 2'd2,
        ST_NOT_READY = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT    = 1'd0,
        CFG_DECIMATION = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  timeout_ms;
        logic [DECIM_W-1:0] decimation;
    } cfg_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]         now_ms;
        logic                      probe_applied;
        logic [QUALITY_W-1:0]      quality;
        logic [READ_INDEX_W-1:0]   read_index;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] read_data;
        logic [COUNT_W-1:0]        count;
        logic                      owned;
        logic                      capturing;
        logic                      ready_res;
        logic                      acquired;
        status_t                   status;
    } result_t;

endpackage

// File: hdl/dsc_core.sv
module dsc_core #(
    parameter int unsigned BUFFER_DEPTH = dsc_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dsc_pkg::cfg_t                           cfg,
    // read port, issued when a word is taken in
    input  logic                                    rd_en,
    input  logic [dsc_pkg::READ_INDEX_W-1:0]        rd_index,
    // word held in the input register and its commit strobe
    input  dsc_pkg::item_t                          item,
    input  logic                                    step,
    output dsc_pkg::result_t                        res
);

    localparam int unsigned ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);

    logic [dsc_pkg::SAMPLE_W-1:0] mem [BUFFER_DEPTH];
    logic [dsc_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]            rd_addr;

    logic [CNT_W-1:0]             count_reg, count_next, count_after;
    logic [dsc_pkg::DECIM_W-1:0]  decim_cnt_reg, decim_cnt_next, decim_inc;
    logic                         active_reg, active_next;
    logic                         ready_reg, ready_next;
    logic                         owned_reg, owned_next;
    logic [dsc_pkg::TIME_W-1:0]   start_time_reg, start_time_next;

    logic                         timed_out;
    logic                         wr_en;
    logic                         in_range;

    assign rd_addr  = ADDR_W'(rd_index);
    assign in_range = 32'(item.read_index) < 32'(BUFFER_DEPTH);

    // forward a same-cycle write so the next word reads fresh data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= item.sample;
        end
        if (rd_en)
        begin
            if (wr_en && (count_reg[ADDR_W-1:0] == rd_addr))
            begin
                rd_data_reg <= item.sample;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    always_comb
    begin
        timed_out       = (item.now_ms - start_time_reg) > cfg.timeout_ms;
        decim_inc       = decim_cnt_reg + 8'd1;
        count_after     = (count_reg < DEPTH_CNT) ? CNT_W'(count_reg + 1'b1) : count_reg;

        count_next      = count_reg;
        decim_cnt_next  = decim_cnt_reg;
        active_next     = active_reg;
        ready_next      = ready_reg;
        owned_next      = owned_reg;
        start_time_next = start_time_reg;
        wr_en           = 1'b0;

        res.status      = dsc_pkg::ST_NONE;
        res.acquired    = 1'b0;
        res.read_data   = '0;

        unique case (item.operation)
            dsc_pkg::OP_FEED:
            begin
                if (active_reg)
                begin
                    if (timed_out)
                    begin
                        active_next = 1'b0;
                    end
                    else if (decim_inc < cfg.decimation)
                    begin
                        decim_cnt_next = decim_inc;
                    end
                    else
                    begin
                        decim_cnt_next = '0;
                        wr_en          = step && (count_reg < DEPTH_CNT);
                        count_next     = count_after;
                        if (count_after >= DEPTH_CNT)
                        begin
                            active_next = 1'b0;
                            ready_next  = 1'b1;
                        end
                    end
                end
            end
            dsc_pkg::OP_REQUEST:
            begin
                if (owned_reg || (active_reg && !timed_out))
                begin
                    res.status = dsc_pkg::ST_BUSY;
                end
                else if (!item.probe_applied || (item.quality != dsc_pkg::QUALITY_GOOD))
                begin
                    // a timed-out capture is dropped even when the start fails
                    active_next = 1'b0;
                    res.status  = dsc_pkg::ST_NOT_READY;
                end
                else
                begin
                    count_next      = '0;
                    decim_cnt_next  = '0;
                    ready_next      = 1'b0;
                    start_time_next = item.now_ms;
                    active_next     = 1'b1;
                    res.status      = dsc_pkg::ST_STARTED;
                end
            end
            dsc_pkg::OP_CLEAR:
            begin
                ready_next = 1'b0;
                count_next = '0;
            end
            dsc_pkg::OP_ACQUIRE:
            begin
                if (ready_reg && !owned_reg)
                begin
                    owned_next   = 1'b1;
                    res.acquired = 1'b1;
                end
            end
            dsc_pkg::OP_RELEASE:
            begin
                owned_next = 1'b0;
                ready_next = 1'b0;
                count_next = '0;
            end
            dsc_pkg::OP_READ:
            begin
                if (in_range)
                begin
                    res.read_data = rd_data_reg;
                end
            end
            default:
            begin
            end
        endcase

        res.ready_res = ready_next;
        res.capturing = active_next;
        res.owned     = owned_next;
        res.count     = dsc_pkg::COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            decim_cnt_reg  <= '0;
            active_reg     <= 1'b0;
            ready_reg      <= 1'b0;
            owned_reg      <= 1'b0;
            start_time_reg <= '0;
        end
        else if (step)
        begin
            count_reg      <= count_next;
            decim_cnt_reg  <= decim_cnt_next;
            active_reg     <= active_next;
            ready_reg      <= ready_next;
            owned_reg      <= owned_next;
            start_time_reg <= start_time_next;
        end
    end

    a_ready_not_capturing: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready_reg && active_reg))
        else $error("snapshot ready while a capture is running");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("stored count beyond buffer depth");

    a_start_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (item.operation == dsc_pkg::OP_REQUEST) && (res.status == dsc_pkg::ST_STARTED))
        |=> (active_reg && (count_reg == '0) && !ready_reg))
        else $error("capture start did not reset the buffer state");

    a_acquire_owns: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.acquired) |=> owned_reg)
        else $error("successful acquire did not claim the snapshot");

endmodule

// File: hdl/decimating_snapshot_capture.sv
// Snapshot capture with decimation. Every input word carries one operation in tuser
// (feed, request, clear, try acquire, release, read) and produces exactly one result
// word. One word is taken per clock cycle unless the input is stalled. Each word
// is held in the input register, where the sample buffer's registered read port is also
// looked up, and then moves to the result register, from which its result word leaves.
// Back-pressure on the result side stalls the input only once both registers hold words.
// The sample buffer is BUFFER_DEPTH entries with one write and one read a cycle; entries
// not yet written read undefined.
// Configuration writes are always accepted and should be made only while the block idles.
module decimating_snapshot_capture #(
    parameter int unsigned BUFFER_DEPTH = dsc_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dsc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dsc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input words
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample[31:0], now_ms[63:32], probe_applied[64], quality[72:65], read_index[81:73]
    input  logic [dsc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // operation[2:0]
    input  logic [dsc_pkg::OP_W-1:0]             s_axis_tuser,
    // result words
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // status[1:0], acquired[2], ready_res[3], capturing[4], owned[5], count[15:6],
    // read_data[47:16]
    output logic [dsc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    dsc_pkg::cfg_t    cfg_reg;
    dsc_pkg::item_t   in_item;
    dsc_pkg::item_t   item_reg;
    dsc_pkg::result_t res;
    dsc_pkg::result_t res_reg;

    logic item_valid_reg;
    logic out_valid_reg;
    logic step;
    logic accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms <= dsc_pkg::TIMEOUT_RESET;
            cfg_reg.decimation <= dsc_pkg::DECIMATION_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (dsc_pkg::cfg_reg_t'(cfg_index))
                dsc_pkg::CFG_TIMEOUT:    cfg_reg.timeout_ms <= cfg_data;
                dsc_pkg::CFG_DECIMATION: cfg_reg.decimation <= cfg_data[dsc_pkg::DECIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_item.operation     = dsc_pkg::op_t'(s_axis_tuser);
    assign in_item.sample        = s_axis_tdata[31:0];
    assign in_item.now_ms        = s_axis_tdata[63:32];
    assign in_item.probe_applied = s_axis_tdata[64];
    assign in_item.quality       = s_axis_tdata[72:65];
    assign in_item.read_index    = s_axis_tdata[81:73];

    assign step          = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !item_valid_reg || step;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                item_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    dsc_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rd_en    (accept),
        .rd_index (in_item.read_index),
        .item     (item_reg),
        .step     (step),
        .res      (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;

endmodule
